[hw/rtl/rsfp_pkg.sv]
// Package for the serial frame packer: frame constants, register indexes and
// the configuration register type. It depends on nothing else.
`default_nettype none

package rsfp_pkg;

   localparam int CHAN_CNT_W = 4;
   localparam int CHANNEL_BITS = 11;
   localparam int QUEUE_DEPTH = 5;

   localparam logic [7:0] START_LOW_TYPES = 8'h55;
   localparam logic [7:0] START_HIGH_TYPES = 8'h54;
   localparam logic [10:0] CHANNEL_MAX = 11'd2047;
   localparam logic signed [13:0] CHANNEL_MID = 14'sd1024;
   // Reciprocal of five scaled by two to the eighteenth, exact for the scaled range.
   localparam logic [15:0] RECIP_FIVE = 16'd52429;
   localparam int RECIP_SHIFT = 18;

   typedef enum logic [2:0] {
      CSR_PROTO_TYPE   = 3'd0,
      CSR_BIND_REQUEST = 3'd1,
      CSR_RANGE_CHECK  = 3'd2,
      CSR_AUTOBIND_BIT = 3'd3,
      CSR_SUB_TYPE     = 3'd4,
      CSR_MODEL_NUMBER = 3'd5,
      CSR_LOW_POWER    = 3'd6,
      CSR_OPTION_BYTE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [5:0] proto_type;
      logic       bind_request;
      logic       range_check;
      logic       autobind_bit;
      logic [2:0] sub_type;
      logic [3:0] model_number;
      logic       low_power;
      logic [7:0] option_byte;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/rc_serial_frame_packer_unit.sv]
// Top level of the serial frame packer: input register, channel scaling,
// bit packing and an output byte queue. It depends on rsfp_pkg.
`default_nettype none

// Each accepted channel sample is converted to an 11-bit value and packed LSB
// first into frame bytes; the first channel of a frame is preceded by four
// header bytes taken from the configuration registers at that moment. An item
// waits in the input register and then loads one to five bytes into a small
// output queue, which sends one byte per cycle while rsp_tready is high: a
// channel gives one or two bytes, the first channel of a frame five, and a last
// channel whose bits do not end on a byte boundary one more. The byte output
// port sets that rate; the next item is taken while the last queued byte
// leaves, so bytes flow without gaps. The final byte of each frame carries
// rsp_tlast.
module rc_serial_frame_packer_unit #(
   parameter int NUM_CHANNELS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // Bits 11:0 channel_value, bits 21:12 center_offset, bits 23:22 zero.
   input  wire logic [23:0]            req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // Bits 7:0 out_byte.
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire rsfp_pkg::csr_index_type csr_index,
   input  wire logic [7:0]             csr_data
);
   import rsfp_pkg::*;

   cfg_type cfg_ff;

   logic                     a_valid_ff;
   logic signed [11:0]       a_chan_ff;
   logic signed [9:0]        a_off_ff;

   logic [CHAN_CNT_W-1:0]    chan_cnt_ff, chan_cnt_in;
   logic [6:0]               acc_ff, acc_in;
   logic [2:0]               held_ff, held_in;

   logic [7:0]               q_ff [QUEUE_DEPTH];
   logic [7:0]               q_in [QUEUE_DEPTH];
   logic [2:0]               cnt_ff, cnt_in;
   logic                     end_ff;

   logic signed [12:0]       sum;
   logic [12:0]              abs13;
   logic [13:0]              times4;
   logic [29:0]              product;
   logic [11:0]              quot;
   logic signed [13:0]       q_s;
   logic signed [13:0]       scaled;
   logic signed [13:0]       biased;
   logic [10:0]              value;
   logic [17:0]              packed_bits;
   logic [4:0]               new_bits;
   logic                     two_full;
   logic                     last;
   logic                     hdr;
   logic [2:0]               data_cnt;
   logic [7:0]               h0, h1, h2, h3;
   logic                     load;
   logic                     rsp_fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PROTO_TYPE:   cfg_ff.proto_type <= csr_data[5:0];
            CSR_BIND_REQUEST: cfg_ff.bind_request <= csr_data[0];
            CSR_RANGE_CHECK:  cfg_ff.range_check <= csr_data[0];
            CSR_AUTOBIND_BIT: cfg_ff.autobind_bit <= csr_data[0];
            CSR_SUB_TYPE:     cfg_ff.sub_type <= csr_data[2:0];
            CSR_MODEL_NUMBER: cfg_ff.model_number <= csr_data[3:0];
            CSR_LOW_POWER:    cfg_ff.low_power <= csr_data[0];
            CSR_OPTION_BYTE:  cfg_ff.option_byte <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = q_ff[0];
   assign rsp_tlast  = end_ff && (cnt_ff == 3'd1);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign load       = a_valid_ff && ((cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_tready));
   assign req_tready = !a_valid_ff || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_chan_ff <= $signed(req_tdata[11:0]);
         a_off_ff  <= $signed(req_tdata[21:12]);
      end
   end

   // Channel scaling: sample plus twice the offset, times 4/5 toward zero, plus 1024, clamped to 0..2047.
   always_comb begin
      sum     = $signed({a_chan_ff[11], a_chan_ff})
              + $signed({{2{a_off_ff[9]}}, a_off_ff, 1'b0});
      abs13   = sum[12] ? (~sum + 13'd1) : sum;
      times4  = {abs13[11:0], 2'b00};
      product = 30'(times4) * 30'(RECIP_FIVE);
      quot    = product[29:RECIP_SHIFT];
      q_s     = $signed({2'b00, quot});
      scaled  = sum[12] ? -q_s : q_s;
      biased  = scaled + CHANNEL_MID;
      if (biased < 14'sd0) begin
         value = 11'd0;
      end else if (biased > $signed({3'b000, CHANNEL_MAX})) begin
         value = CHANNEL_MAX;
      end else begin
         value = biased[10:0];
      end
   end

   always_comb begin
      h0 = cfg_ff.proto_type[5] ? START_HIGH_TYPES : START_LOW_TYPES;
      h1 = {cfg_ff.bind_request, cfg_ff.autobind_bit,
            !cfg_ff.bind_request && cfg_ff.range_check, cfg_ff.proto_type[4:0]};
      h2 = {cfg_ff.low_power, cfg_ff.sub_type, cfg_ff.model_number};
      h3 = cfg_ff.option_byte;
   end

   always_comb begin
      hdr         = (chan_cnt_ff == '0);
      last        = (chan_cnt_ff == CHAN_CNT_W'(NUM_CHANNELS - 1));
      packed_bits = (18'(value) << held_ff) | {11'd0, acc_ff};
      new_bits    = {2'b00, held_ff} + 5'(CHANNEL_BITS);
      two_full    = new_bits[4];
      if (two_full) begin
         data_cnt = (last && (new_bits != 5'd16)) ? 3'd3 : 3'd2;
      end else begin
         data_cnt = last ? 3'd2 : 3'd1;
      end

      if (last) begin
         chan_cnt_in = '0;
         acc_in      = '0;
         held_in     = '0;
      end else begin
         chan_cnt_in = chan_cnt_ff + CHAN_CNT_W'(1);
         acc_in      = two_full ? {5'd0, packed_bits[17:16]} : packed_bits[14:8];
         held_in     = new_bits[2:0];
      end
   end

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (load) begin
         if (hdr) begin
            q_in[0] = h0;
            q_in[1] = h1;
            q_in[2] = h2;
            q_in[3] = h3;
            q_in[4] = packed_bits[7:0];
            cnt_in  = 3'(QUEUE_DEPTH);
         end else begin
            q_in[0] = packed_bits[7:0];
            q_in[1] = packed_bits[15:8];
            q_in[2] = {6'd0, packed_bits[17:16]};
            cnt_in  = data_cnt;
         end
      end else if (rsp_fire) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= 3'd0;
         end_ff      <= 1'b0;
         chan_cnt_ff <= '0;
         acc_ff      <= '0;
         held_ff     <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (load) begin
            end_ff      <= last;
            chan_cnt_ff <= chan_cnt_in;
            acc_ff      <= acc_in;
            held_ff     <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

`default_nettype wire

[hw/rtl/rsfp_checker.sv]
// Port-level checks for the serial frame packer and the bind that attaches
// them to the top level. It depends on rsfp_pkg and rc_serial_frame_packer_unit.
`default_nettype none

module rsfp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic       csr_valid,
   input wire logic       csr_ready
);
   import rsfp_pkg::*;

   logic frame_start_ff;

   // A frame begins after reset and after every item that carries tlast.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         frame_start_ff <= rsp_tlast;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled output item changed.");

   a_start_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && frame_start_ff |->
         (rsp_tdata == START_LOW_TYPES) || (rsp_tdata == START_HIGH_TYPES))
      else $error("Frame does not open with a start byte.");

   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && frame_start_ff |-> !rsp_tlast)
      else $error("Start byte marked as frame end.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Output item presented right after reset.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("Configuration write was held off.");

endmodule

bind rc_serial_frame_packer_unit rsfp_checker u_rsfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rc_serial_frame_packer_unit: it drives channel samples and
// register writes, predicts every frame byte and compares it with the byte stream.
// It depends on rsfp_pkg and the packer RTL.

module testbench;
   import rsfp_pkg::*;

   localparam int N_CH = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int N_PHASES = 9;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   typedef struct packed {
      csr_index_type index;
      logic [7:0]    data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_PROTO_TYPE;
   logic [7:0] csr_data = '0;

   cfg_type cfg_shadow = '0;
   int unsigned chan_pos = 0;
   logic [31:0] bit_acc = '0;
   int unsigned bits_in_acc = 0;

   logic [23:0] pending_items[$];
   frame_byte_type bytes_due[$];
   reg_write_type reg_queue[$];

   bit send_idle_en = 1'b0;
   bit recv_idle_en = 1'b0;
   bit pressure_req = 1'b0;
   bit pressure_done = 1'b0;
   int send_gap = 0;
   int recv_stall = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   rc_serial_frame_packer_unit #(.NUM_CHANNELS(N_CH)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic [10:0] scale_channel(logic signed [11:0] cv, logic signed [9:0] co);
      int v;
      v = int'(cv) + 2 * int'(co);
      v = v * 8 / 10 + 1024;
      if (v < 0) v = 0;
      if (v > 2047) v = 2047;
      return v[10:0];
   endfunction

   task automatic predict_frame_bytes(input logic [23:0] item);
      logic [7:0] proto_byte;
      logic last_chan;
      if (chan_pos == 0) begin
         bit_acc = '0;
         bits_in_acc = 0;
         proto_byte = {cfg_shadow.bind_request, cfg_shadow.autobind_bit,
                       !cfg_shadow.bind_request && cfg_shadow.range_check,
                       cfg_shadow.proto_type[4:0]};
         bytes_due.push_back('{(cfg_shadow.proto_type <= 31) ? START_LOW_TYPES
                                                               : START_HIGH_TYPES, 1'b0});
         bytes_due.push_back('{proto_byte, 1'b0});
         bytes_due.push_back('{{cfg_shadow.low_power, cfg_shadow.sub_type,
                                cfg_shadow.model_number}, 1'b0});
         bytes_due.push_back('{cfg_shadow.option_byte, 1'b0});
      end
      last_chan = (chan_pos + 1 >= N_CH);
      bit_acc |= {21'b0, scale_channel(item[11:0], item[21:12])} << (bits_in_acc & 7);
      bits_in_acc = (bits_in_acc & 7) + CHANNEL_BITS;
      while (bits_in_acc >= 8) begin
         bytes_due.push_back('{bit_acc[7:0], last_chan && bits_in_acc == 8});
         bit_acc = bit_acc >> 8;
         bits_in_acc -= 8;
      end
      if (last_chan) begin
         if (bits_in_acc > 0) bytes_due.push_back('{bit_acc[7:0], 1'b1});
         bit_acc = '0;
         bits_in_acc = 0;
         chan_pos = 0;
      end else begin
         chan_pos++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) predict_frame_bytes(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_tdata <= pending_items.pop_front();
               req_tvalid <= 1'b1;
               if (send_idle_en) send_gap = draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected byte 0x%02h last %0b", $time, rsp_tdata, rsp_tlast);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: byte expected 0x%02h last %0b, got 0x%02h last %0b",
                              $time, want.data, want.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            recv_stall = PRESSURE_CYCLES;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (recv_idle_en && $urandom_range(0, 3) == 0) recv_stall = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic push_channel(input logic signed [11:0] cv, input logic signed [9:0] co);
      pending_items.push_back({2'b00, co, cv});
   endtask

   function automatic logic [23:0] random_item();
      logic signed [11:0] cv;
      logic signed [9:0] co;
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         cv = 12'(int'($urandom_range(0, 2048)) - 1024);
         co = 10'(int'($urandom_range(0, 100)) - 50);
      end else if (r < 9) begin
         cv = 12'($urandom);
         co = 10'($urandom);
      end else begin
         cv = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
         co = $urandom_range(0, 1) ? 10'sd511 : -10'sd512;
      end
      return {2'b00, co, cv};
   endfunction

   // Called at a rising edge; the valid stays high across back-to-back writes.
   task automatic program_regs(input logic [5:0] pt, input logic bind_req, input logic rng,
                               input logic autob, input logic [2:0] st, input logic [3:0] mn,
                               input logic lp, input logic [7:0] ob);
      reg_write_type w;
      reg_queue.push_back('{CSR_PROTO_TYPE, {2'b00, pt}});
      reg_queue.push_back('{CSR_BIND_REQUEST, {7'b0, bind_req}});
      reg_queue.push_back('{CSR_RANGE_CHECK, {7'b0, rng}});
      reg_queue.push_back('{CSR_AUTOBIND_BIT, {7'b0, autob}});
      reg_queue.push_back('{CSR_SUB_TYPE, {5'b0, st}});
      reg_queue.push_back('{CSR_MODEL_NUMBER, {4'b0, mn}});
      reg_queue.push_back('{CSR_LOW_POWER, {7'b0, lp}});
      reg_queue.push_back('{CSR_OPTION_BYTE, ob});
      while (reg_queue.size() > 0) begin
         w = reg_queue.pop_front();
         csr_index <= w.index;
         csr_data <= w.data;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         case (w.index)
            CSR_PROTO_TYPE:   cfg_shadow.proto_type = w.data[5:0];
            CSR_BIND_REQUEST: cfg_shadow.bind_request = w.data[0];
            CSR_RANGE_CHECK:  cfg_shadow.range_check = w.data[0];
            CSR_AUTOBIND_BIT: cfg_shadow.autobind_bit = w.data[0];
            CSR_SUB_TYPE:     cfg_shadow.sub_type = w.data[2:0];
            CSR_MODEL_NUMBER: cfg_shadow.model_number = w.data[3:0];
            CSR_LOW_POWER:    cfg_shadow.low_power = w.data[0];
            CSR_OPTION_BYTE:  cfg_shadow.option_byte = w.data;
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Idle is judged at the falling edge, where all clocked updates have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || bytes_due.size() != 0);
      @(posedge clock);
   endtask

   initial begin
      int n_items;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Saturation at both ends, truncation toward zero and the clamp boundaries.
      push_channel(-2048, -512);
      push_channel(2047, 511);
      push_channel(-2048, 0);
      push_channel(2047, 0);
      push_channel(0, 0);
      push_channel(-1, 0);
      push_channel(1, 0);
      push_channel(-4, 0);
      push_channel(4, 0);
      push_channel(-5, 0);
      push_channel(5, 0);
      push_channel(-1024, 0);
      push_channel(1024, 0);
      push_channel(0, -512);
      push_channel(0, 511);
      push_channel(-1280, 0);
      push_channel(-1281, 0);
      push_channel(-1282, 0);
      push_channel(1278, 0);
      push_channel(1279, 0);
      push_channel(1280, 0);
      push_channel(12'sh555, 10'sh2AA);
      push_channel(12'shAAA, 10'sh155);
      push_channel(0, 1);
      push_channel(0, -1);
      wait_idle();

      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: program_regs(6'd63, 1'b1, 1'b1, 1'b1, 3'd7, 4'd15, 1'b1, 8'hFF);
            1: program_regs(6'd31, 1'b0, 1'b1, 1'b0, 3'd0, 4'd0, 1'b0, 8'h00);
            2: program_regs(6'd32, 1'b0, 1'b0, 1'b1, 3'd5, 4'd10, 1'b1, 8'hA5);
            default: program_regs(6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                  3'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
         endcase
         send_idle_en = (p % 3 != 1);
         recv_idle_en = (p % 4 != 2);
         n_items = $urandom_range(12, 32);
         if (p == 3) begin
            send_idle_en = 1'b0;
            n_items = 40;
            pressure_req = 1'b1;
         end
         repeat (n_items) pending_items.push_back(random_item());
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && bytes_due.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/rsfp_pkg.sv
hw/rtl/rc_serial_frame_packer_unit.sv
hw/rtl/rsfp_checker.sv
tb/testbench.sv
